FILE: sv/sbbf_pkg.sv
// ----------------------------------------------------------------------------
// sbbf_pkg: shared types and constants of the split block Bloom filter
// Holds the filter geometry, the hash constants, the word types of both
// channels, the controller states and the controller-to-datapath signals.
// ----------------------------------------------------------------------------
package sbbf_pkg;

  // Filter geometry. The bucket count is a power of two, so wrapping a
  // bucket index into the store is a plain truncation.
  localparam int unsigned NUM_BUCKETS      = 1024;
  localparam int unsigned WORDS_PER_BUCKET = 8;
  localparam int unsigned WORD_W           = 32;
  localparam int unsigned ROW_W            = WORDS_PER_BUCKET * WORD_W;
  localparam int unsigned BKT_W            = $clog2(NUM_BUCKETS);

  // Bucket mask register.
  localparam int unsigned      MASK_W     = 10;
  localparam logic [MASK_W-1:0] MASK_RESET = 10'h3FF;

  // Hash constants.
  localparam logic [WORD_W-1:0] GOLDEN_MULT = 32'h9E37_79B9;
  localparam int unsigned       POS_W       = 5;
  localparam int unsigned       POS_LSB     = WORD_W - POS_W;

  localparam logic [WORD_W-1:0] SEEDS [WORDS_PER_BUCKET] = '{
    32'h14EB_CDFF, 32'h2A1C_1A99, 32'h85CB_78FB, 32'h6E8F_82DD,
    32'hF846_4DFF, 32'h1028_FEAD, 32'h74F0_4A4D, 32'h1832_DB75
  };

  // Request codes.
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [WORD_W-1:0] key;
  } req_t;

  typedef struct packed {
    logic was_query;
    logic found;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_READ,
    ST_CHECK
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_key;  // capture the accepted request word
    logic hash_en;   // register bucket index and bit positions
    logic rd_en;     // read the bucket row
    logic commit;    // update the row on insert and load the result
    logic clr_en;    // zero one row of the store
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;  // the clearing pass is on its last row
  } sts_t;

endpackage

FILE: sv/sbbf_ram.sv
// ----------------------------------------------------------------------------
// sbbf_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; no reset on the contents.
// ----------------------------------------------------------------------------
module sbbf_ram #(
  parameter  int unsigned WIDTH = 32,
  parameter  int unsigned DEPTH = 1024,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/sbbf_ctrl.sv
// ----------------------------------------------------------------------------
// sbbf_ctrl: controller of the split block Bloom filter
// Sequences the clearing pass and the hash, read and check steps of each
// request, and owns the valid flag of the result register.
// ----------------------------------------------------------------------------
module sbbf_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output sbbf_pkg::cmd_t cmd_o,
  input  sbbf_pkg::sts_t sts_i
);

  sbbf_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sbbf_pkg::ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      sbbf_pkg::ST_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        if (sts_i.clr_last) begin
          state_d = sbbf_pkg::ST_IDLE;
        end
      end
      sbbf_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load_key = 1'b1;
          state_d        = sbbf_pkg::ST_HASH;
        end
      end
      sbbf_pkg::ST_HASH: begin
        cmd_o.hash_en = 1'b1;
        state_d       = sbbf_pkg::ST_READ;
      end
      sbbf_pkg::ST_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = sbbf_pkg::ST_CHECK;
      end
      sbbf_pkg::ST_CHECK: begin
        // The result register must be free or emptying this cycle.
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.commit = 1'b1;
          state_d      = sbbf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = sbbf_pkg::ST_IDLE;
      end
    endcase
    out_valid_d = cmd_o.commit | (out_valid_q & out_stall_i);
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: sv/sbbf_dp.sv
// ----------------------------------------------------------------------------
// sbbf_dp: datapath of the split block Bloom filter
// Hash multipliers, bucket mask register, clear counter, filter store and
// the result register payload.
// ----------------------------------------------------------------------------
module sbbf_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sbbf_pkg::MASK_W-1:0]   cfg_wdata_i,
  input  sbbf_pkg::req_t                in_word_i,
  output sbbf_pkg::rsp_t                out_word_o,
  input  sbbf_pkg::cmd_t                cmd_i,
  output sbbf_pkg::sts_t                sts_o
);

  logic [sbbf_pkg::MASK_W-1:0]  mask_q;
  logic [sbbf_pkg::BKT_W-1:0]   clr_cnt_q;
  logic                         is_query_q;
  logic [sbbf_pkg::WORD_W-1:0]  key_q;
  logic [sbbf_pkg::BKT_W-1:0]   bkt_q;
  logic [sbbf_pkg::POS_W-1:0]   pos_q [sbbf_pkg::WORDS_PER_BUCKET];
  sbbf_pkg::rsp_t               rsp_q;

  logic [2*sbbf_pkg::WORD_W-1:0] gold_prod;
  logic [sbbf_pkg::MASK_W-1:0]   bkt_masked;
  logic [sbbf_pkg::WORD_W-1:0]   seed_prod [sbbf_pkg::WORDS_PER_BUCKET];
  logic [sbbf_pkg::ROW_W-1:0]    row_rd;
  logic [sbbf_pkg::ROW_W-1:0]    row_new;
  logic                          hit;

  logic                          ram_we;
  logic [sbbf_pkg::BKT_W-1:0]    ram_waddr;
  logic [sbbf_pkg::ROW_W-1:0]    ram_wdata;

  // Configuration and clear counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q    <= sbbf_pkg::MASK_RESET;
      clr_cnt_q <= '0;
    end else begin
      if (cfg_we_i) begin
        mask_q <= cfg_wdata_i;
      end
      if (cmd_i.clr_en) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
    end
  end

  assign sts_o.clr_last =
    (clr_cnt_q == sbbf_pkg::BKT_W'(sbbf_pkg::NUM_BUCKETS - 1));

  // Hashes: one multiplier for the bucket, one per word for the bit position.
  assign gold_prod  = {{sbbf_pkg::WORD_W{1'b0}}, key_q} *
                      {{sbbf_pkg::WORD_W{1'b0}}, sbbf_pkg::GOLDEN_MULT};
  assign bkt_masked = gold_prod[sbbf_pkg::WORD_W +: sbbf_pkg::MASK_W] & mask_q;

  always_comb begin
    for (int i = 0; i < sbbf_pkg::WORDS_PER_BUCKET; i++) begin
      seed_prod[i] = sbbf_pkg::SEEDS[i] * key_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_key) begin
      is_query_q <= (in_word_i.req_type == sbbf_pkg::REQ_QUERY);
      key_q      <= in_word_i.key;
    end
    if (cmd_i.hash_en) begin
      bkt_q <= bkt_masked[sbbf_pkg::BKT_W-1:0];
      for (int i = 0; i < sbbf_pkg::WORDS_PER_BUCKET; i++) begin
        pos_q[i] <= seed_prod[i][sbbf_pkg::POS_LSB +: sbbf_pkg::POS_W];
      end
    end
    if (cmd_i.commit) begin
      rsp_q.was_query <= is_query_q;
      rsp_q.found     <= is_query_q & hit;
    end
  end

  // Test and set of the eight selected bits.
  always_comb begin
    hit     = 1'b1;
    row_new = row_rd;
    for (int i = 0; i < sbbf_pkg::WORDS_PER_BUCKET; i++) begin
      hit = hit & row_rd[i*sbbf_pkg::WORD_W + int'(pos_q[i])];
      row_new[i*sbbf_pkg::WORD_W + int'(pos_q[i])] = 1'b1;
    end
  end

  assign ram_we    = cmd_i.clr_en | (cmd_i.commit & ~is_query_q);
  assign ram_waddr = cmd_i.clr_en ? clr_cnt_q : bkt_q;
  assign ram_wdata = cmd_i.clr_en ? '0 : row_new;

  sbbf_ram #(
    .WIDTH (sbbf_pkg::ROW_W),
    .DEPTH (sbbf_pkg::NUM_BUCKETS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (bkt_q),
    .rdata_o (row_rd)
  );

  assign out_word_o = rsp_q;

endmodule

FILE: sv/split_block_bloom_filter.sv
// ----------------------------------------------------------------------------
// split_block_bloom_filter: blocked Bloom filter over 32-bit keys
// Top level joining the controller and the datapath.
// ----------------------------------------------------------------------------
// A request word carries a key and a type, insert or query. The key picks a
// bucket of eight 32-bit words from the upper half of key times 0x9E3779B9,
// ANDed with the bucket mask register, and one bit in each word from the top
// five bits of the low half of a per-word seed times the key. An insert sets
// the eight bits and returns a word with was_query and found low; a query
// returns found high only if all eight bits are set. The result register is
// loaded once a request has passed the hash multiply, the bucket row read and
// the test and update, and the next request is accepted in the cycle after
// the result is loaded, so the block does not take a new request before the
// last one is through. The controller takes one request at a time through
// its capture, hash, read and check steps. A finished result
// sits in an output register, so a new request can be accepted while the
// previous result is still stalled; if that word is still stalled when the
// next request reaches its check step, the controller waits there and the
// input stays stalled until the word is taken. After reset the block zeroes
// the store one bucket a cycle across the whole store, and in_stall_o stays
// high until it is done; mask writes are taken at any time, but should only
// be made while the block is idle.
module split_block_bloom_filter (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [sbbf_pkg::MASK_W-1:0] cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  sbbf_pkg::req_t              in_word_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output sbbf_pkg::rsp_t              out_word_o
);

  sbbf_pkg::cmd_t cmd;
  sbbf_pkg::sts_t sts;

  // The controller decides when each step happens.
  sbbf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // The datapath holds the store, the hashes and the result payload.
  sbbf_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_word_i   (in_word_i),
    .out_word_o  (out_word_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

FILE: sv/sbbf_checker.sv
// ----------------------------------------------------------------------------
// sbbf_checker: port-level checks of the split block Bloom filter
// Watches the top level's ports and is bound to every instance of it.
// ----------------------------------------------------------------------------
module sbbf_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input sbbf_pkg::rsp_t out_word_o
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled result word changed");

  // An insert acknowledge never reports a hit.
  a_insert_no_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.was_query |-> !out_word_o.found)
    else $error("insert acknowledge reports found");

  // Only one request is in flight at a time.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted in back-to-back cycles");

  // A result that appears in an empty output register follows an accepted request.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 4))
    else $error("result without matching request");

endmodule

bind split_block_bloom_filter sbbf_checker u_sbbf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);
